### rtl/dbcs_pkg.sv
// Shared types and codes for the double-buffered channel store.
`timescale 1ns / 1ps
`default_nettype none
package dbcs_pkg;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_GET    = 2'd1,
    CMD_RUN    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_GET  = 2'd0,
    KIND_DUMP = 2'd1,
    KIND_DROP = 2'd2,
    KIND_RSVD = 2'd3
  } kind_e;

  localparam int unsigned RunCap = 16;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] key;
    logic [63:0] ttag;
    logic [63:0] value;
  } item_t;

endpackage
`default_nettype wire

### rtl/dbcs_in_if.sv
// Command channel: valid/ready with one command as payload.
`timescale 1ns / 1ps
`default_nettype none
interface dbcs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] channel_id;
  logic [63:0] time_tag;
  logic [63:0] sample_value;

  modport source (output valid, command, channel_id, time_tag, sample_value, input ready);
  modport sink (input valid, command, channel_id, time_tag, sample_value, output ready);
endinterface
`default_nettype wire

### rtl/dbcs_out_if.sv
// Result channel: valid/ready with one result as payload.
`timescale 1ns / 1ps
`default_nettype none
interface dbcs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        found;
  logic [31:0] out_channel;
  logic [63:0] out_time;
  logic [63:0] out_value;
  logic        last;

  modport source (output valid, kind, found, out_channel, out_time, out_value, last,
                  input ready);
  modport sink (input valid, kind, found, out_channel, out_time, out_value, last,
                output ready);
endinterface
`default_nettype wire

### rtl/dbcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module dbcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/dbcs_fifo.sv
// Two-entry queue between the hashing front and the table back end.
`timescale 1ns / 1ps
`default_nettype none
module dbcs_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  pop_valid_o,
  input  wire logic             pop_ready_i,
  output logic      [WIDTH-1:0] pop_data_o
);
  logic [WIDTH-1:0] buf_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = buf_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wptr_q] <= push_data_i;
  end
endmodule
`default_nettype wire

### rtl/dbcs_front.sv
// Front end: takes commands, computes the chain slot by reciprocal multiply, queues them.
`timescale 1ns / 1ps
`default_nettype none
module dbcs_front #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned HASH_MOD = 16,
  localparam int unsigned SLW     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dbcs_in_if.sink    in_i,
  output logic       push_valid_o,
  input  wire logic  push_ready_i,
  output logic [SLW+$bits(dbcs_pkg::item_t)-1:0] push_data_o
);
  typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} fstate_e;

  // floor((2^32-1)/d): the estimated quotient is at most 2 below the true one
  localparam logic [31:0] RECIP_HASH = 32'(32'hFFFF_FFFF / HASH_MOD);
  localparam logic [31:0] RECIP_SLOT = 32'(32'hFFFF_FFFF / SLOTS);

  fstate_e         state_q;
  dbcs_pkg::item_t item_q;
  logic [31:0]     src_q, rem_q, q_q;
  logic [1:0]      cnt_q;
  logic            phase_q;
  logic [31:0]     divisor, recip, qd, reduced;
  logic [63:0]     prod;
  dbcs_pkg::cmd_e  in_cmd;

  assign in_cmd = dbcs_pkg::cmd_e'(in_i.command);

  // per reduction: estimate quotient, subtract q*d, then two compare-and-subtract steps
  always_comb begin
    divisor = phase_q ? 32'(SLOTS) : 32'(HASH_MOD);
    recip   = phase_q ? RECIP_SLOT : RECIP_HASH;
    prod    = {32'd0, src_q} * {32'd0, recip};
    qd      = q_q * divisor;
    reduced = (rem_q >= divisor) ? rem_q - divisor : rem_q;
  end

  assign in_i.ready   = (state_q == F_IDLE);
  assign push_valid_o = (state_q == F_PUSH);
  assign push_data_o  = {rem_q[SLW-1:0], item_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      phase_q <= 1'b0;
      cnt_q   <= 2'd0;
      src_q   <= '0;
      rem_q   <= '0;
      q_q     <= '0;
      item_q  <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_i.valid) begin
            item_q  <= {in_cmd, in_i.channel_id, in_i.time_tag, in_i.sample_value};
            src_q   <= in_i.channel_id;
            rem_q   <= '0;
            cnt_q   <= 2'd0;
            phase_q <= 1'b0;
            if (in_cmd == dbcs_pkg::CMD_RECORD || in_cmd == dbcs_pkg::CMD_GET) begin
              state_q <= F_HASH;
            end else if (in_cmd == dbcs_pkg::CMD_RUN) begin
              state_q <= F_PUSH;
            end
          end
        end
        F_HASH: begin
          cnt_q <= cnt_q + 2'd1;
          case (cnt_q)
            2'd0: q_q <= prod[63:32];
            2'd1: rem_q <= src_q - qd;
            2'd2: rem_q <= reduced;
            default: begin
              if (!phase_q) begin
                phase_q <= 1'b1;
                src_q   <= reduced;
              end else begin
                rem_q   <= reduced;
                state_q <= F_PUSH;
              end
            end
          endcase
        end
        F_PUSH: begin
          if (push_ready_i) state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/dbcs_back.sv
// Back end: chain walks, bucket allocation, copy swap and dump scan.
`timescale 1ns / 1ps
`default_nettype none
module dbcs_back #(
  parameter int unsigned SLOTS   = 16,
  parameter int unsigned BUCKETS = 64,
  localparam int unsigned SLW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  pop_valid_i,
  output logic       pop_ready_o,
  input  wire logic [SLW+$bits(dbcs_pkg::item_t)-1:0] pop_data_i,
  input  wire logic [4:0] max_per_run_i,
  dbcs_out_if.source out_o
);
  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned AW = BW + 1;
  localparam int unsigned HW = SLW + 1;
  localparam int unsigned DW = 160;

  typedef enum logic [3:0] {
    B_IDLE, B_WAIT, B_CHECK, B_MISS, B_LINK, B_EMIT, B_CLR, B_SCAN, B_SWAIT, B_CAP
  } bstate_e;

  bstate_e         state_q;
  dbcs_pkg::item_t item_q, pop_item;
  logic [SLW-1:0]  slot_q, pop_slot;
  logic            active_q;
  logic [BW:0]     free_q [2];
  logic [(1<<HW)-1:0] head_v_q;
  logic [BW-1:0]   head_i_q [1<<HW];
  logic [AW-1:0]   rd_addr_q;
  logic [BW-1:0]   tail_q, nb_q;
  logic            has_tail_q;
  logic [BW:0]     b_q;
  logic [4:0]      cnt_q, limit_q;

  logic        pend_v_q, pend_found_q;
  logic [1:0]  pend_kind_q;
  logic [31:0] pend_chan_q;
  logic [63:0] pend_time_q, pend_val_q;

  logic        out_v_q, out_found_q, out_last_q;
  logic [1:0]  out_kind_q;
  logic [31:0] out_chan_q;
  logic [63:0] out_time_q, out_val_q;

  logic          d_we, l_we, u_we;
  logic [AW-1:0] d_waddr, l_waddr, u_waddr;
  logic [DW-1:0] d_wdata, d_rdata;
  logic [BW:0]   l_wdata, l_rdata;
  logic          u_wdata, u_rdata;

  logic [BW:0]   fa, fo;
  logic          full, old, key_hit, cand, out_free, cap_go, out_load;
  logic [HW-1:0] head_sel;

  assign {pop_slot, pop_item} = pop_data_i;
  assign fa       = free_q[active_q];
  assign old      = ~active_q;
  assign fo       = free_q[old];
  assign full     = (fa >= (BW+1)'(BUCKETS));
  assign key_hit  = (d_rdata[159:128] == item_q.key);
  // only allocated buckets carry a defined updated mark
  assign cand     = u_rdata && (b_q < fo);
  assign out_free = !out_v_q || out_o.ready;
  assign head_sel = {active_q, pop_slot};
  assign cap_go   = (state_q == B_CAP) && cand && (!pend_v_q || out_free);
  assign out_load = ((state_q == B_EMIT) && out_free) || (cap_go && pend_v_q);

  assign pop_ready_o     = (state_q == B_IDLE);
  assign out_o.valid       = out_v_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.found       = out_found_q;
  assign out_o.out_channel = out_chan_q;
  assign out_o.out_time    = out_time_q;
  assign out_o.out_value   = out_val_q;
  assign out_o.last        = out_last_q;

  always_comb begin
    d_we    = 1'b0;
    d_waddr = rd_addr_q;
    d_wdata = {item_q.key, item_q.ttag, item_q.value};
    l_we    = 1'b0;
    l_waddr = {active_q, tail_q};
    l_wdata = {1'b1, fa[BW-1:0]};
    u_we    = 1'b0;
    u_waddr = rd_addr_q;
    u_wdata = 1'b1;
    case (state_q)
      B_CHECK: begin
        d_we = key_hit && (item_q.cmd == dbcs_pkg::CMD_RECORD);
        u_we = key_hit && (item_q.cmd == dbcs_pkg::CMD_RECORD);
      end
      B_MISS: begin
        if (item_q.cmd == dbcs_pkg::CMD_RECORD && !full) begin
          d_we    = 1'b1;
          d_waddr = {active_q, fa[BW-1:0]};
          l_we    = has_tail_q;
          u_we    = 1'b1;
          u_waddr = {active_q, fa[BW-1:0]};
        end
      end
      B_LINK: begin
        // a fresh bucket terminates its chain
        l_we    = 1'b1;
        l_waddr = {active_q, nb_q};
        l_wdata = '0;
      end
      B_CLR: begin
        u_we    = 1'b1;
        u_waddr = {active_q, b_q[BW-1:0]};
        u_wdata = 1'b0;
      end
      B_CAP: begin
        u_we    = cap_go;
        u_wdata = 1'b0;
      end
      default: ;
    endcase
  end

  dbcs_ram #(.WIDTH(DW), .DEPTH(1 << AW)) u_data_ram (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(rd_addr_q), .rdata_o(d_rdata)
  );

  dbcs_ram #(.WIDTH(BW + 1), .DEPTH(1 << AW)) u_link_ram (
    .clk_i(clk_i), .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(rd_addr_q), .rdata_o(l_rdata)
  );

  dbcs_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_upd_ram (
    .clk_i(clk_i), .we_i(u_we), .waddr_i(u_waddr), .wdata_i(u_wdata),
    .raddr_i(rd_addr_q), .rdata_o(u_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      item_q       <= '0;
      slot_q       <= '0;
      active_q     <= 1'b0;
      free_q[0]    <= '0;
      free_q[1]    <= '0;
      head_v_q     <= '0;
      for (int i = 0; i < (1 << HW); i++) head_i_q[i] <= '0;
      rd_addr_q    <= '0;
      tail_q       <= '0;
      nb_q         <= '0;
      has_tail_q   <= 1'b0;
      b_q          <= '0;
      cnt_q        <= '0;
      limit_q      <= '0;
      pend_v_q     <= 1'b0;
      pend_found_q <= 1'b0;
      pend_kind_q  <= '0;
      pend_chan_q  <= '0;
      pend_time_q  <= '0;
      pend_val_q   <= '0;
      out_v_q      <= 1'b0;
      out_found_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_kind_q   <= '0;
      out_chan_q   <= '0;
      out_time_q   <= '0;
      out_val_q    <= '0;
    end else begin
      if (out_load) out_v_q <= 1'b1;
      else if (out_o.ready) out_v_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (pop_valid_i) begin
            item_q     <= pop_item;
            slot_q     <= pop_slot;
            has_tail_q <= 1'b0;
            case (pop_item.cmd)
              dbcs_pkg::CMD_RUN: begin
                active_q <= ~active_q;
                limit_q  <= (max_per_run_i > 5'(dbcs_pkg::RunCap)) ?
                            5'(dbcs_pkg::RunCap) : max_per_run_i;
                b_q      <= '0;
                cnt_q    <= '0;
                pend_v_q <= 1'b0;
                state_q  <= B_CLR;
              end
              dbcs_pkg::CMD_RECORD, dbcs_pkg::CMD_GET: begin
                if (head_v_q[head_sel]) begin
                  rd_addr_q <= {active_q, head_i_q[head_sel]};
                  state_q   <= B_WAIT;
                end else begin
                  state_q <= B_MISS;
                end
              end
              default: ;
            endcase
          end
        end
        B_WAIT: state_q <= B_CHECK;
        B_CHECK: begin
          if (key_hit) begin
            if (item_q.cmd == dbcs_pkg::CMD_RECORD) begin
              state_q <= B_IDLE;
            end else begin
              pend_kind_q  <= dbcs_pkg::KIND_GET;
              pend_found_q <= 1'b1;
              pend_chan_q  <= item_q.key;
              pend_time_q  <= d_rdata[127:64];
              pend_val_q   <= d_rdata[63:0];
              state_q      <= B_EMIT;
            end
          end else begin
            tail_q     <= rd_addr_q[BW-1:0];
            has_tail_q <= 1'b1;
            if (l_rdata[BW]) begin
              rd_addr_q <= {active_q, l_rdata[BW-1:0]};
              state_q   <= B_WAIT;
            end else begin
              state_q <= B_MISS;
            end
          end
        end
        B_MISS: begin
          pend_found_q <= 1'b0;
          pend_chan_q  <= item_q.key;
          pend_time_q  <= '0;
          pend_val_q   <= '0;
          if (item_q.cmd == dbcs_pkg::CMD_GET) begin
            pend_kind_q <= dbcs_pkg::KIND_GET;
            state_q     <= B_EMIT;
          end else if (full) begin
            pend_kind_q <= dbcs_pkg::KIND_DROP;
            state_q     <= B_EMIT;
          end else begin
            if (!has_tail_q) begin
              head_v_q[{active_q, slot_q}] <= 1'b1;
              head_i_q[{active_q, slot_q}] <= fa[BW-1:0];
            end
            free_q[active_q] <= fa + (BW+1)'(1);
            nb_q             <= fa[BW-1:0];
            state_q          <= B_LINK;
          end
        end
        B_LINK: state_q <= B_IDLE;
        B_EMIT: begin
          if (out_free) begin
            out_kind_q  <= pend_kind_q;
            out_found_q <= pend_found_q;
            out_chan_q  <= pend_chan_q;
            out_time_q  <= pend_time_q;
            out_val_q   <= pend_val_q;
            out_last_q  <= 1'b1;
            pend_v_q    <= 1'b0;
            state_q     <= B_IDLE;
          end
        end
        B_CLR: begin
          // wipe the updated marks of the newly active copy, one bucket per cycle
          if (b_q == (BW+1)'(BUCKETS - 1)) begin
            b_q     <= '0;
            state_q <= B_SCAN;
          end else begin
            b_q <= b_q + (BW+1)'(1);
          end
        end
        B_SCAN: begin
          if (b_q == (BW+1)'(BUCKETS) || cnt_q == limit_q) begin
            state_q <= pend_v_q ? B_EMIT : B_IDLE;
          end else begin
            rd_addr_q <= {old, b_q[BW-1:0]};
            state_q   <= B_SWAIT;
          end
        end
        B_SWAIT: state_q <= B_CAP;
        B_CAP: begin
          if (!cand) begin
            b_q     <= b_q + (BW+1)'(1);
            state_q <= B_SCAN;
          end else if (!pend_v_q || out_free) begin
            // hold one entry back so the final one can carry last
            if (pend_v_q) begin
              out_kind_q  <= pend_kind_q;
              out_found_q <= pend_found_q;
              out_chan_q  <= pend_chan_q;
              out_time_q  <= pend_time_q;
              out_val_q   <= pend_val_q;
              out_last_q  <= 1'b0;
            end
            pend_v_q     <= 1'b1;
            pend_kind_q  <= dbcs_pkg::KIND_DUMP;
            pend_found_q <= 1'b0;
            pend_chan_q  <= d_rdata[159:128];
            pend_time_q  <= d_rdata[127:64];
            pend_val_q   <= d_rdata[63:0];
            cnt_q        <= cnt_q + 5'd1;
            b_q          <= b_q + (BW+1)'(1);
            state_q      <= B_SCAN;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/double_buffered_channel_store.sv
// Top level: config register, hashing front, queue and table back end.
// Front: takes a command, hashes a record or get (reciprocal multiply and two corrections, for
//   HASH_MOD then SLOTS) and queues it (a run unhashed); it takes no new command until that one is queued.
// Back: pops an item, walks the chain bucket by bucket, appends a bucket on a record miss and
//   hands a result to the output register; a run clears the updated marks, then scans the old copy.
// Reset clears chain heads, free counts and the active copy at once; updated marks are only
//   read for allocated buckets, so they need no clearing pass. max_per_run resets to 3.
`timescale 1ns / 1ps
`default_nettype none
module double_buffered_channel_store #(
  parameter int unsigned SLOTS    = 16,
  parameter int unsigned BUCKETS  = 64,
  parameter int unsigned HASH_MOD = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_data_i,
  dbcs_in_if.sink         in_i,
  dbcs_out_if.source      out_o
);
  localparam int unsigned SLW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned QW  = SLW + $bits(dbcs_pkg::item_t);

  logic [4:0]    max_q;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0] push_data, pop_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 5'd3;
    end else if (cfg_we_i) begin
      max_q <= cfg_data_i;
    end
  end

  dbcs_front #(.SLOTS(SLOTS), .HASH_MOD(HASH_MOD)) u_front (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_i),
    .push_valid_o(push_valid), .push_ready_i(push_ready), .push_data_o(push_data)
  );

  dbcs_fifo #(.WIDTH(QW)) u_fifo (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push_valid_i(push_valid), .push_ready_o(push_ready), .push_data_i(push_data),
    .pop_valid_o(pop_valid), .pop_ready_i(pop_ready), .pop_data_o(pop_data)
  );

  dbcs_back #(.SLOTS(SLOTS), .BUCKETS(BUCKETS)) u_back (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .pop_valid_i(pop_valid), .pop_ready_o(pop_ready), .pop_data_i(pop_data),
    .max_per_run_i(max_q), .out_o(out_o)
  );
endmodule
`default_nettype wire

### rtl/dbcs_checker.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dbcs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        valid_i,
  input wire logic        ready_i,
  input wire logic [1:0]  kind_i,
  input wire logic        found_i,
  input wire logic [63:0] time_i,
  input wire logic        last_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(kind_i) && $stable(time_i))
    else $error("result changed while stalled");

  a_found_get_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_i != dbcs_pkg::KIND_GET |-> !found_i)
    else $error("found set on a non-get result");

  a_drop_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_i == dbcs_pkg::KIND_DROP |-> last_i && time_i == 64'd0)
    else $error("malformed drop result");

  a_get_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && kind_i == dbcs_pkg::KIND_GET |-> last_i && (found_i || time_i == 64'd0))
    else $error("malformed get answer");

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> kind_i != dbcs_pkg::KIND_RSVD)
    else $error("reserved result kind");
endmodule

bind double_buffered_channel_store dbcs_checker u_dbcs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .valid_i(out_o.valid), .ready_i(out_o.ready),
  .kind_i(out_o.kind), .found_i(out_o.found), .time_i(out_o.out_time),
  .last_i(out_o.last)
);
`default_nettype wire
